>>> hw/rtl/assert_macros.svh
// Assertion macros for the checker module of the stress block.
// Holds only macro definitions; it depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent at the same clock edge.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent after the delay n given to the macro.
`define CHK_DELAY(label, clk, rst, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/stvk_pkg.sv
// Package of the StVK stress block: fixed-point types, widths, rounding
// constants and index tables. It depends on nothing else.
`default_nettype none

package stvk_pkg;

  // Field and register widths.
  localparam int F_W   = 24;
  localparam int CFG_W = 24;
  localparam int P_W   = 32;

  // Internal widths, sized for the worst case of every input pattern.
  localparam int FPROD_W = 2 * F_W;
  localparam int CSUM_W  = 51;
  localparam int E_W     = 32;
  localparam int TR_W    = 34;
  localparam int MTERM_W = 58;
  localparam int VSUM_W  = 60;
  localparam int S_W     = 34;
  localparam int SPROD_W = 58;
  localparam int ACC_W   = 60;

  // Fractional bits dropped at each rounding step.
  localparam int E_SHIFT   = 17;
  localparam int S_SHIFT   = 24;
  localparam int P_SHIFT   = 16;
  localparam int Q40_SHIFT = 40;

  typedef logic signed [F_W-1:0]     fval_t;
  typedef logic signed [FPROD_W-1:0] fprod_t;
  typedef logic signed [CSUM_W-1:0]  csum_t;
  typedef logic signed [E_W-1:0]     eval_t;
  typedef logic signed [TR_W-1:0]    trace_t;
  typedef logic signed [MTERM_W-1:0] mterm_t;
  typedef logic signed [VSUM_W-1:0]  vsum_t;
  typedef logic signed [S_W-1:0]     sval_t;
  typedef logic signed [SPROD_W-1:0] sprod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [P_W-1:0]     pval_t;
  typedef logic [CFG_W-1:0]          mu_t;
  typedef logic signed [CFG_W-1:0]   lambda_t;

  // Control that travels down the pipeline beside the data.
  typedef struct packed {
    logic valid;
    logic mixed;
  } ctl_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_SHEAR  = 1'b0,
    REG_LAMBDA = 1'b1
  } cfg_reg_t;

  localparam mu_t     SHEAR_RESET  = mu_t'(65536);
  localparam lambda_t LAMBDA_RESET = lambda_t'(65536);

  // Identity in Q.40 and the half-LSB terms for round half up.
  localparam csum_t ONE_Q40 = csum_t'(1) << Q40_SHIFT;
  localparam csum_t E_RND   = csum_t'(1) << (E_SHIFT - 1);
  localparam vsum_t S_RND   = vsum_t'(1) << (S_SHIFT - 1);
  localparam acc_t  P_RND   = acc_t'(1) << (P_SHIFT - 1);

  // Strain and stress are symmetric; only six entries are kept, in the order
  // 00, 01, 02, 11, 12, 22.
  localparam int SYM_ROW [6] = '{0, 0, 0, 1, 1, 2};
  localparam int SYM_COL [6] = '{0, 1, 2, 1, 2, 2};
  // Row-major 3x3 position to its slot among the six kept entries.
  localparam int SYM_IDX [9] = '{0, 1, 2, 1, 3, 4, 2, 4, 5};

endpackage

`default_nettype wire

>>> hw/rtl/stvk_strain.sv
// Green strain E = 0.5 (F^T F - I), two register stages: products, then
// sum with rounding to Q.24. Depends on stvk_pkg.
`default_nettype none

module stvk_strain (
  input  logic               clk,
  input  logic               rst,
  input  stvk_pkg::ctl_t     ctl_in,
  input  stvk_pkg::fval_t    f [9],
  output stvk_pkg::ctl_t     ctl_out,
  output stvk_pkg::eval_t    e [6]
);

  stvk_pkg::ctl_t   ctl1;
  stvk_pkg::fprod_t prod [6][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl_out <= '0;
    end else begin
      ctl1    <= ctl_in;
      ctl_out <= ctl1;
    end
  end

  // Stage 1: column products of F for the six kept entries of F^T F.
  always_ff @(posedge clk) begin
    for (int u = 0; u < 6; u++) begin
      for (int k = 0; k < 3; k++) begin
        prod[u][k] <= f[3*k + stvk_pkg::SYM_ROW[u]] * f[3*k + stvk_pkg::SYM_COL[u]];
      end
    end
  end

  // Stage 2: sum, remove the identity on the diagonal, round to Q.24.
  for (genvar gu = 0; gu < 6; gu++) begin : g_e
    localparam bit DIAG = (stvk_pkg::SYM_ROW[gu] == stvk_pkg::SYM_COL[gu]);
    stvk_pkg::csum_t csum;
    stvk_pkg::csum_t rnd;

    assign csum = stvk_pkg::csum_t'(prod[gu][0]) + stvk_pkg::csum_t'(prod[gu][1])
                + stvk_pkg::csum_t'(prod[gu][2]);
    assign rnd  = csum - (DIAG ? stvk_pkg::ONE_Q40 : '0) + stvk_pkg::E_RND;

    always_ff @(posedge clk) begin
      e[gu] <= rnd[stvk_pkg::E_SHIFT +: stvk_pkg::E_W];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/stvk_fmul.sv
// Product P = F S with rounding to Q.20 and saturation to 32 bits, two
// register stages. Depends on stvk_pkg.
`default_nettype none

module stvk_fmul (
  input  logic               clk,
  input  logic               rst,
  input  stvk_pkg::ctl_t     ctl_in,
  input  stvk_pkg::fval_t    f [9],
  input  stvk_pkg::sval_t    s [6],
  output stvk_pkg::ctl_t     ctl_out,
  output stvk_pkg::pval_t    p [9]
);

  localparam int R_W = stvk_pkg::ACC_W - stvk_pkg::P_SHIFT;

  stvk_pkg::ctl_t   ctl6;
  stvk_pkg::sprod_t prod [9][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl6    <= '0;
      ctl_out <= '0;
    end else begin
      ctl6    <= ctl_in;
      ctl_out <= ctl6;
    end
  end

  // Stage 6: the 27 products f[i][k] * s[k][j].
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          prod[3*i + j][k] <= f[3*i + k] * s[stvk_pkg::SYM_IDX[3*k + j]];
        end
      end
    end
  end

  // Stage 7: sum, round half up, clamp to the 32-bit range.
  for (genvar gn = 0; gn < 9; gn++) begin : g_p
    stvk_pkg::acc_t     acc;
    logic signed [R_W-1:0] r;
    logic                  fits;

    assign acc  = stvk_pkg::acc_t'(prod[gn][0]) + stvk_pkg::acc_t'(prod[gn][1])
                + stvk_pkg::acc_t'(prod[gn][2]) + stvk_pkg::P_RND;
    assign r    = acc[stvk_pkg::P_SHIFT +: R_W];
    assign fits = (r[R_W-1:stvk_pkg::P_W-1] == '0) || (r[R_W-1:stvk_pkg::P_W-1] == '1);

    always_ff @(posedge clk) begin
      if (fits) begin
        p[gn] <= r[stvk_pkg::P_W-1:0];
      end else if (r[R_W-1]) begin
        p[gn] <= {1'b1, {(stvk_pkg::P_W-1){1'b0}}};
      end else begin
        p[gn] <= {1'b0, {(stvk_pkg::P_W-1){1'b1}}};
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/stvk_piola_stress_top.sv
// Top level of the StVK first Piola-Kirchhoff stress block: ports, Lame
// registers and the stress stages. Depends on stvk_pkg, stvk_strain, stvk_fmul.
`default_nettype none

// Saint Venant-Kirchhoff stress unit. Each item is one 3x3 deformation
// gradient F in signed Q4.20 plus a mode bit; the block returns
// P = F (2 mu E + lambda tr(E) I) in full mode, or P = F (2 mu E) in mixed
// mode, where E = 0.5 (F^T F - I), as nine signed Q12.20 entries saturated at
// the 32-bit limits. The block is a seven-stage pipeline with no feedback:
// an item is taken at every clock edge where start is high and busy is low,
// so one item per cycle is sustained, and each result appears on p_00..p_22
// with done high for exactly one cycle. Results come out in the order the
// items went in. The receiver cannot hold results off, and none is needed:
// nothing inside the pipeline ever waits. The seven register stages are:
// F^T F products, strain sum and rounding, the 2 mu E products with the
// trace, the lambda tr(E) product, stress sum and rounding, the F S products,
// and the final sum with rounding and saturation. busy is high only during
// reset. The Lame parameters are written through cfg_wr_en, cfg_index and
// cfg_data (index 0 shear modulus in unsigned Q8.16, index 1 lambda in signed
// Q8.16, both reset to 1.0) and must only change while no item is in flight.
module stvk_piola_stress_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  output logic                                  done,
  input  logic                                  req_type,
  input  logic signed [stvk_pkg::F_W-1:0]       f_00,
  input  logic signed [stvk_pkg::F_W-1:0]       f_01,
  input  logic signed [stvk_pkg::F_W-1:0]       f_02,
  input  logic signed [stvk_pkg::F_W-1:0]       f_10,
  input  logic signed [stvk_pkg::F_W-1:0]       f_11,
  input  logic signed [stvk_pkg::F_W-1:0]       f_12,
  input  logic signed [stvk_pkg::F_W-1:0]       f_20,
  input  logic signed [stvk_pkg::F_W-1:0]       f_21,
  input  logic signed [stvk_pkg::F_W-1:0]       f_22,
  output logic signed [stvk_pkg::P_W-1:0]       p_00,
  output logic signed [stvk_pkg::P_W-1:0]       p_01,
  output logic signed [stvk_pkg::P_W-1:0]       p_02,
  output logic signed [stvk_pkg::P_W-1:0]       p_10,
  output logic signed [stvk_pkg::P_W-1:0]       p_11,
  output logic signed [stvk_pkg::P_W-1:0]       p_12,
  output logic signed [stvk_pkg::P_W-1:0]       p_20,
  output logic signed [stvk_pkg::P_W-1:0]       p_21,
  output logic signed [stvk_pkg::P_W-1:0]       p_22,
  input  logic                                  cfg_wr_en,
  input  logic [0:0]                            cfg_index,
  input  logic [stvk_pkg::CFG_W-1:0]            cfg_data
);

  // F must reach the final product unit together with S, which is ready
  // after five stages.
  localparam int F_DELAY = 5;

  stvk_pkg::mu_t     shear_modulus;
  stvk_pkg::lambda_t bulk_lame_lambda;

  stvk_pkg::ctl_t    ctl0;
  stvk_pkg::ctl_t    ctl2;
  stvk_pkg::ctl_t    ctl3;
  stvk_pkg::ctl_t    ctl4;
  stvk_pkg::ctl_t    ctl5;
  stvk_pkg::ctl_t    ctl7;

  stvk_pkg::fval_t   f_in   [9];
  stvk_pkg::fval_t   f_pipe [F_DELAY][9];
  stvk_pkg::eval_t   e2     [6];
  stvk_pkg::mterm_t  m2e3   [6];
  stvk_pkg::mterm_t  m2e4   [6];
  stvk_pkg::trace_t  tr3;
  stvk_pkg::mterm_t  lt4;
  stvk_pkg::sval_t   s5     [6];
  stvk_pkg::pval_t   p7     [9];

  // The pipeline can take an item in every cycle outside reset.
  assign busy       = rst;
  assign ctl0.valid = start && !busy;
  assign ctl0.mixed = req_type;

  assign f_in[0] = f_00;
  assign f_in[1] = f_01;
  assign f_in[2] = f_02;
  assign f_in[3] = f_10;
  assign f_in[4] = f_11;
  assign f_in[5] = f_12;
  assign f_in[6] = f_20;
  assign f_in[7] = f_21;
  assign f_in[8] = f_22;

  // Lame parameter registers. The index is one bit wide, so every write
  // lands on one of the two registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      shear_modulus    <= stvk_pkg::SHEAR_RESET;
      bulk_lame_lambda <= stvk_pkg::LAMBDA_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        stvk_pkg::REG_SHEAR:  shear_modulus    <= cfg_data;
        stvk_pkg::REG_LAMBDA: bulk_lame_lambda <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stages 1 and 2: Green strain.
  stvk_strain u_strain (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl0),
    .f       (f_in),
    .ctl_out (ctl2),
    .e       (e2)
  );

  // F delay line that keeps the gradient beside its item.
  always_ff @(posedge clk) begin
    f_pipe[0] <= f_in;
    for (int d = 1; d < F_DELAY; d++) begin
      f_pipe[d] <= f_pipe[d-1];
    end
  end

  // Control bits (valid and mode) of the stress stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3 <= '0;
      ctl4 <= '0;
      ctl5 <= '0;
    end else begin
      ctl3 <= ctl2;
      ctl4 <= ctl3;
      ctl5 <= ctl4;
    end
  end

  // Stage 3: 2 mu E for every kept entry, and the trace of E.
  // Stage 4: lambda tr(E); the shear terms move along beside it.
  always_ff @(posedge clk) begin
    for (int u = 0; u < 6; u++) begin
      m2e3[u] <= $signed({1'b0, shear_modulus, 1'b0}) * e2[u];
      m2e4[u] <= m2e3[u];
    end
    tr3 <= stvk_pkg::trace_t'(e2[0]) + stvk_pkg::trace_t'(e2[3])
         + stvk_pkg::trace_t'(e2[5]);
    lt4 <= bulk_lame_lambda * tr3;
  end

  // Stage 5: S = 2 mu E, plus lambda tr(E) on the diagonal in full mode,
  // rounded half up to Q.16.
  for (genvar gu = 0; gu < 6; gu++) begin : g_s
    localparam bit DIAG = (stvk_pkg::SYM_ROW[gu] == stvk_pkg::SYM_COL[gu]);
    stvk_pkg::vsum_t v;

    assign v = stvk_pkg::vsum_t'(m2e4[gu])
             + ((DIAG && !ctl4.mixed) ? stvk_pkg::vsum_t'(lt4) : '0)
             + stvk_pkg::S_RND;

    always_ff @(posedge clk) begin
      s5[gu] <= v[stvk_pkg::S_SHIFT +: stvk_pkg::S_W];
    end
  end

  // Stages 6 and 7: P = F S with saturation.
  stvk_fmul u_fmul (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl5),
    .f       (f_pipe[F_DELAY-1]),
    .s       (s5),
    .ctl_out (ctl7),
    .p       (p7)
  );

  assign done = ctl7.valid;
  assign p_00 = p7[0];
  assign p_01 = p7[1];
  assign p_02 = p7[2];
  assign p_10 = p7[3];
  assign p_11 = p7[4];
  assign p_12 = p7[5];
  assign p_20 = p7[6];
  assign p_21 = p7[7];
  assign p_22 = p7[8];

endmodule

`default_nettype wire

>>> hw/rtl/stvk_chk.sv
// Port-level checker of the StVK stress block and its bind to the top level.
// Depends on assert_macros.svh and stvk_piola_stress_top.
`default_nettype none

`include "assert_macros.svh"

module stvk_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [23:0] f_00,
  input logic [23:0] f_01,
  input logic [23:0] f_02,
  input logic [23:0] f_10,
  input logic [23:0] f_11,
  input logic [23:0] f_12,
  input logic [23:0] f_20,
  input logic [23:0] f_21,
  input logic [23:0] f_22,
  input logic [31:0] p_00,
  input logic [31:0] p_01,
  input logic [31:0] p_02,
  input logic [31:0] p_10,
  input logic [31:0] p_11,
  input logic [31:0] p_12,
  input logic [31:0] p_20,
  input logic [31:0] p_21,
  input logic [31:0] p_22
);

  logic accept;
  logic f_zero;
  logic p_zero;

  assign accept = start && !busy;
  assign f_zero = (f_00 == '0) && (f_01 == '0) && (f_02 == '0) && (f_10 == '0)
               && (f_11 == '0) && (f_12 == '0) && (f_20 == '0) && (f_21 == '0)
               && (f_22 == '0);
  assign p_zero = (p_00 == '0) && (p_01 == '0) && (p_02 == '0) && (p_10 == '0)
               && (p_11 == '0) && (p_12 == '0) && (p_20 == '0) && (p_21 == '0)
               && (p_22 == '0);

  // Every accepted item yields its result once it has passed the pipeline.
  `CHK_DELAY(a_result_follows, clk, rst, accept, 7, done, "accepted item gave no result")

  // No result appears without an accepted item that went in before it.
  `CHK_IMPLY(a_no_spurious, clk, rst, done, $past(accept, 7), "result without an item")

  // The pipeline never refuses an item outside reset.
  `CHK_IMPLY(a_never_busy, clk, rst, 1'b1, !busy, "busy outside reset")

  // A zero gradient gives zero stress in either mode and for any parameters.
  `CHK_DELAY(a_zero_in_zero_out, clk, rst, accept && f_zero, 7, p_zero, "nonzero stress")

endmodule

bind stvk_piola_stress_top stvk_chk u_chk (.*);

`default_nettype wire
